>>> sv/flhs_pkg.sv
`timescale 1ns / 1ps

package flhs_pkg;

  // Number of levels scanned; only the first min(LEVEL_COUNT, TABLE_LEVELS) exist.
  localparam int LEVEL_COUNT  = 8;
  localparam int TABLE_LEVELS = 8;
  localparam int USED_LEVELS  = (LEVEL_COUNT < TABLE_LEVELS) ? LEVEL_COUNT : TABLE_LEVELS;

  localparam int PCT_W   = 7;
  localparam int RPM_W   = 13;
  localparam int LEVEL_W = 3;
  localparam int TSEL_W  = 2;

  localparam logic [PCT_W-1:0]   PCT_MAX   = PCT_W'(100);
  localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(USED_LEVELS - 1);

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_SCAN,
    CTRL_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    DIR_HOLD,
    DIR_DOWN,
    DIR_UP
  } dir_e;

  typedef enum logic [TSEL_W-1:0] {
    CURVE_A = 2'd0,
    CURVE_B = 2'd1,
    CURVE_C = 2'd2
  } curve_e;

  typedef struct packed {
    logic [PCT_W-1:0] up;
    logic [PCT_W-1:0] down;
    logic [RPM_W-1:0] speed;
  } point_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic               scan_done;
    logic [LEVEL_W-1:0] level;
  } dp_status_t;

  function automatic point_t mk(input int up, input int down, input int speed);
    point_t p;
    p.up    = PCT_W'(up);
    p.down  = PCT_W'(down);
    p.speed = RPM_W'(speed);
    return p;
  endfunction

  // Built-in fan curves. An unused table code falls back to the first curve.
  function automatic point_t curve_point(input logic [TSEL_W-1:0] tsel,
                                         input logic [LEVEL_W-1:0] idx);
    point_t p;
    p = mk(0, 1, 0);
    unique case (tsel)
      CURVE_B: begin
        unique case (idx)
          3'd0:    p = mk(0, 1, 0);
          3'd1:    p = mk(36, 1, 2800);
          3'd2:    p = mk(62, 58, 3200);
          3'd3:    p = mk(68, 63, 3400);
          3'd4:    p = mk(75, 69, 4200);
          3'd5:    p = mk(81, 76, 4800);
          3'd6:    p = mk(88, 83, 5200);
          default: p = mk(98, 91, 5600);
        endcase
      end
      CURVE_C: begin
        unique case (idx)
          3'd0:    p = mk(0, 1, 0);
          3'd1:    p = mk(36, 1, 2200);
          3'd2:    p = mk(63, 56, 2900);
          3'd3:    p = mk(69, 65, 3000);
          3'd4:    p = mk(75, 70, 3300);
          3'd5:    p = mk(80, 76, 3600);
          3'd6:    p = mk(87, 81, 3900);
          default: p = mk(98, 91, 5000);
        endcase
      end
      default: begin
        unique case (idx)
          3'd0:    p = mk(0, 1, 0);
          3'd1:    p = mk(36, 1, 2800);
          3'd2:    p = mk(58, 58, 3200);
          3'd3:    p = mk(66, 61, 3400);
          3'd4:    p = mk(75, 69, 4200);
          3'd5:    p = mk(81, 76, 4800);
          3'd6:    p = mk(88, 83, 5200);
          default: p = mk(98, 91, 5600);
        endcase
      end
    endcase
    return p;
  endfunction

endpackage

>>> sv/flhs_ctrl.sv
`timescale 1ns / 1ps

module flhs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_free_i,
  input  flhs_pkg::dp_status_t  status_i,
  output logic                  in_ready_o,
  output flhs_pkg::dp_cmd_t     cmd_o
);

  flhs_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flhs_pkg::CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      flhs_pkg::CTRL_IDLE: begin
        if (in_valid_i) begin
          state_d = flhs_pkg::CTRL_SCAN;
        end
      end
      flhs_pkg::CTRL_SCAN: begin
        if (status_i.scan_done) begin
          state_d = flhs_pkg::CTRL_EMIT;
        end
      end
      flhs_pkg::CTRL_EMIT: begin
        if (out_free_i) begin
          state_d = flhs_pkg::CTRL_IDLE;
        end
      end
      default: state_d = flhs_pkg::CTRL_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == flhs_pkg::CTRL_IDLE);
    cmd_o.load = (state_q == flhs_pkg::CTRL_IDLE) && in_valid_i;
    cmd_o.step = (state_q == flhs_pkg::CTRL_SCAN);
    cmd_o.emit = (state_q == flhs_pkg::CTRL_EMIT) && out_free_i;
  end

endmodule

>>> sv/flhs_datapath.sv
`timescale 1ns / 1ps

module flhs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [flhs_pkg::TSEL_W-1:0]   cfg_wdata_i,
  input  logic [flhs_pkg::PCT_W-1:0]    duty_percent_i,
  input  flhs_pkg::dp_cmd_t             cmd_i,
  output flhs_pkg::dp_status_t          status_o,
  output logic [flhs_pkg::RPM_W-1:0]    speed_o
);

  logic [flhs_pkg::TSEL_W-1:0]  tsel_q;
  logic [flhs_pkg::LEVEL_W-1:0] level_q, level_d;
  logic [flhs_pkg::PCT_W-1:0]   last_pct_q;
  logic [flhs_pkg::PCT_W-1:0]   pct_q;
  flhs_pkg::dir_e               dir_q, dir_d;

  logic [flhs_pkg::PCT_W-1:0]   pct_sat;
  logic [flhs_pkg::LEVEL_W-1:0] level_clamped;
  logic [flhs_pkg::LEVEL_W-1:0] level_next_up;
  flhs_pkg::point_t             pt_here;
  flhs_pkg::point_t             pt_above;
  logic                         done;

  assign pct_sat = (duty_percent_i > flhs_pkg::PCT_MAX) ? flhs_pkg::PCT_MAX : duty_percent_i;
  assign level_clamped = (level_q > flhs_pkg::LEVEL_TOP) ? flhs_pkg::LEVEL_TOP : level_q;
  assign level_next_up = level_q + flhs_pkg::LEVEL_W'(1);

  assign pt_here  = flhs_pkg::curve_point(tsel_q, level_q);
  assign pt_above = flhs_pkg::curve_point(tsel_q, level_next_up);

  // One level per cycle; the scan stops at the first level that fails its test.
  always_comb begin
    unique case (dir_q)
      flhs_pkg::DIR_DOWN: done = (pct_q > pt_here.down) || (level_q == '0);
      flhs_pkg::DIR_UP:   done = (level_q == flhs_pkg::LEVEL_TOP) || (pct_q < pt_above.up);
      default:            done = 1'b1;
    endcase
  end

  always_comb begin
    level_d = level_q;
    dir_d   = dir_q;
    if (cmd_i.load) begin
      level_d = level_clamped;
      if (pct_sat < last_pct_q) begin
        dir_d = flhs_pkg::DIR_DOWN;
      end else if (pct_sat > last_pct_q) begin
        dir_d = flhs_pkg::DIR_UP;
      end else begin
        dir_d = flhs_pkg::DIR_HOLD;
      end
    end else if (cmd_i.step && !done) begin
      if (dir_q == flhs_pkg::DIR_DOWN) begin
        level_d = level_q - flhs_pkg::LEVEL_W'(1);
      end else begin
        level_d = level_next_up;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsel_q     <= '0;
      level_q    <= '0;
      last_pct_q <= '0;
      dir_q      <= flhs_pkg::DIR_HOLD;
    end else begin
      if (cfg_we_i) begin
        tsel_q <= cfg_wdata_i;
      end
      level_q <= level_d;
      dir_q   <= dir_d;
      if (cmd_i.load) begin
        last_pct_q <= pct_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pct_q <= pct_sat;
    end
  end

  assign status_o.scan_done = done;
  assign status_o.level     = level_q;
  assign speed_o            = pt_here.speed;

endmodule

>>> sv/fan_level_hysteresis_stepper_top.sv
`timescale 1ns / 1ps

// Fan level stepper with hysteresis.
//
// Input channel: one duty request in percent per transfer on in_valid_i /
// in_ready_o. Requests above 100 are clamped to 100 before use.
// Output channel: one result per request on out_valid_o / out_ready_i,
// carrying the speed target and the level reached.
// Configuration: cfg_we_i writes cfg_wdata_i into the curve select register
// in the same cycle; it should only be written while the block is idle.
//
// The accepting edge loads the request, then a scan that moves at most one
// level per cycle runs until the level is found, and in the emit state the
// output register loads once it is free, which raises out_valid_o. The level
// scan in the datapath sets how long a request takes. The controller is idle
// again right after the output register loads, so a new request can be taken
// while the previous result may still wait in the output register.
// When the receiver stalls, the finished result holds in the output register
// and the next request stops in the emit state until the register frees up.
// Reset clears the level, the last request and the curve select to zero.
module fan_level_hysteresis_stepper_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [flhs_pkg::TSEL_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [flhs_pkg::PCT_W-1:0]    duty_percent_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [flhs_pkg::RPM_W-1:0]    target_rpm_o,
  output logic [flhs_pkg::LEVEL_W-1:0]  fan_level_o
);

  flhs_pkg::dp_cmd_t    dp_cmd;
  flhs_pkg::dp_status_t dp_status;
  logic [flhs_pkg::RPM_W-1:0] dp_speed;

  logic                          out_valid_q;
  logic [flhs_pkg::RPM_W-1:0]    rpm_q;
  logic [flhs_pkg::LEVEL_W-1:0]  level_out_q;
  logic                          out_free;

  // The output register can take a new result when empty or when its
  // current result leaves in this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  flhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (dp_status),
    .in_ready_o (in_ready_o),
    .cmd_o      (dp_cmd)
  );

  flhs_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .duty_percent_i (duty_percent_i),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .speed_o        (dp_speed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dp_cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd.emit) begin
      rpm_q       <= dp_speed;
      level_out_q <= dp_status.level;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign target_rpm_o = rpm_q;
  assign fan_level_o  = level_out_q;

  // An accepted request takes the controller out of idle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("controller stayed ready after an input transfer");

  // A new result only appears after the controller emitted one.
  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(dp_cmd.emit))
    else $error("output valid rose without an emit command");

  // The level is left alone while no request is in flight.
  a_level_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && !in_valid_i) |=> $stable(dp_status.level))
    else $error("level changed while idle");

  // The emitted level never exceeds the top level in use.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.emit |-> (dp_status.level <= flhs_pkg::LEVEL_TOP))
    else $error("level beyond the last table level");

endmodule

>>> sim/tb_fan_level_hysteresis_stepper_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the fan level stepper. A behavioral copy of the
// three fan curves and of the hysteresis rules predicts the speed and the
// level of every accepted request. A checker compares each result transfer
// against the oldest prediction.
module tb_fan_level_hysteresis_stepper_top;

  // Table code 3 is not a curve of its own; the block falls back to curve A.
  localparam logic [flhs_pkg::TSEL_W-1:0] CURVE_SPARE = 2'd3;

  // Once the queue is empty the block is idle again, because every request
  // yields exactly one result. This settle time only covers the tail at the end.
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTED = 10;

  // One row of a fan curve: the on point, the off point and the speed.
  typedef struct packed {
    logic [flhs_pkg::PCT_W-1:0] on_pct;
    logic [flhs_pkg::PCT_W-1:0] off_pct;
    logic [flhs_pkg::RPM_W-1:0] rpm;
  } curve_row_t;

  typedef struct packed {
    logic [flhs_pkg::RPM_W-1:0]   rpm;
    logic [flhs_pkg::LEVEL_W-1:0] level;
  } fan_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [flhs_pkg::TSEL_W-1:0]  cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  logic [flhs_pkg::PCT_W-1:0]   duty_percent;
  logic                         out_valid;
  logic                         out_ready;
  logic [flhs_pkg::RPM_W-1:0]   target_rpm;
  logic [flhs_pkg::LEVEL_W-1:0] fan_level;

  // Shadow of the block's state; level and last duty follow each request.
  logic [flhs_pkg::TSEL_W-1:0]  curve_sel_q;
  logic [flhs_pkg::LEVEL_W-1:0] level_q;
  logic [flhs_pkg::PCT_W-1:0]   last_pct_q;

  fan_result_t expected_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_left;
  int mismatch_count;
  int requests_sent;
  int results_seen;
  int curve_requests[4];
  logic [7:0] levels_reached;
  logic [flhs_pkg::PCT_W-1:0] last_duty_sent;

  fan_level_hysteresis_stepper_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .duty_percent_i (duty_percent),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .target_rpm_o   (target_rpm),
    .fan_level_o    (fan_level)
  );

  // The three built-in curves, written out row by row. Level 0 is always the
  // off row with a zero speed.
  function automatic curve_row_t curve_row(input logic [flhs_pkg::TSEL_W-1:0] curve,
                                           input int idx);
    curve_row_t r;
    r = '{on_pct: 0, off_pct: 1, rpm: 0};
    case (curve)
      flhs_pkg::CURVE_B: begin
        case (idx)
          1: r = '{on_pct: 36, off_pct: 1,  rpm: 2800};
          2: r = '{on_pct: 62, off_pct: 58, rpm: 3200};
          3: r = '{on_pct: 68, off_pct: 63, rpm: 3400};
          4: r = '{on_pct: 75, off_pct: 69, rpm: 4200};
          5: r = '{on_pct: 81, off_pct: 76, rpm: 4800};
          6: r = '{on_pct: 88, off_pct: 83, rpm: 5200};
          7: r = '{on_pct: 98, off_pct: 91, rpm: 5600};
          default: ;
        endcase
      end
      flhs_pkg::CURVE_C: begin
        case (idx)
          1: r = '{on_pct: 36, off_pct: 1,  rpm: 2200};
          2: r = '{on_pct: 63, off_pct: 56, rpm: 2900};
          3: r = '{on_pct: 69, off_pct: 65, rpm: 3000};
          4: r = '{on_pct: 75, off_pct: 70, rpm: 3300};
          5: r = '{on_pct: 80, off_pct: 76, rpm: 3600};
          6: r = '{on_pct: 87, off_pct: 81, rpm: 3900};
          7: r = '{on_pct: 98, off_pct: 91, rpm: 5000};
          default: ;
        endcase
      end
      default: begin
        case (idx)
          1: r = '{on_pct: 36, off_pct: 1,  rpm: 2800};
          2: r = '{on_pct: 58, off_pct: 58, rpm: 3200};
          3: r = '{on_pct: 66, off_pct: 61, rpm: 3400};
          4: r = '{on_pct: 75, off_pct: 69, rpm: 4200};
          5: r = '{on_pct: 81, off_pct: 76, rpm: 4800};
          6: r = '{on_pct: 88, off_pct: 83, rpm: 5200};
          7: r = '{on_pct: 98, off_pct: 91, rpm: 5600};
          default: ;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [flhs_pkg::TSEL_W-1:0] active_curve();
    return (curve_sel_q == CURVE_SPARE) ? flhs_pkg::CURVE_A : curve_sel_q;
  endfunction

  // Applies one request to the shadow state and returns the result that the
  // block must produce for it. A falling request walks down through off
  // points, a rising one walks up through on points, and an equal one holds.
  function automatic fan_result_t step_fan_level(input logic [flhs_pkg::PCT_W-1:0] duty);
    logic [flhs_pkg::PCT_W-1:0] pct;
    logic [flhs_pkg::TSEL_W-1:0] curve;
    curve_row_t row;
    fan_result_t res;
    int lvl;
    int idx;
    bit walking;
    pct = (duty > flhs_pkg::PCT_MAX) ? flhs_pkg::PCT_MAX : duty;
    curve = active_curve();
    lvl = int'(level_q);
    if (lvl >= flhs_pkg::USED_LEVELS) lvl = flhs_pkg::USED_LEVELS - 1;
    walking = 1'b1;
    if (pct < last_pct_q) begin
      for (idx = lvl; idx >= 0 && walking; idx--) begin
        row = curve_row(curve, idx);
        if (pct <= row.off_pct) lvl = idx - 1;
        else walking = 1'b0;
      end
    end else if (pct > last_pct_q) begin
      for (idx = lvl + 1; idx < flhs_pkg::USED_LEVELS && walking; idx++) begin
        row = curve_row(curve, idx);
        if (pct >= row.on_pct) lvl = idx;
        else walking = 1'b0;
      end
    end
    // A fall through the off point of level 0 leaves the fan at level 0.
    if (lvl < 0) lvl = 0;
    level_q = flhs_pkg::LEVEL_W'(lvl);
    last_pct_q = pct;
    row = curve_row(curve, lvl);
    res.rpm = row.rpm;
    res.level = level_q;
    return res;
  endfunction

  // Half the random requests are small moves around the previous one and values
  // near the thresholds of the current curve, since that is where hysteresis
  // decisions happen. The rest is repeats, wide jumps and out-of-range values.
  function automatic logic [flhs_pkg::PCT_W-1:0] pick_duty(
      input logic [flhs_pkg::PCT_W-1:0] prev);
    int mode;
    int val;
    curve_row_t row;
    mode = $urandom_range(99);
    if (mode < 30) begin
      val = ($urandom_range(1) == 1) ? int'(prev) + $urandom_range(6)
                                     : int'(prev) - $urandom_range(6);
    end else if (mode < 45) begin
      val = prev;
    end else if (mode < 65) begin
      row = curve_row(active_curve(), $urandom_range(flhs_pkg::USED_LEVELS - 1));
      val = ($urandom_range(1) == 1) ? row.on_pct : row.off_pct;
      val = val + $urandom_range(2) - 1;
    end else if (mode < 80) begin
      val = $urandom_range(100);
    end else if (mode < 88) begin
      val = $urandom_range(127, 101);
    end else begin
      val = $urandom_range(127);
    end
    if (val < 0) val = 0;
    if (val > 127) val = 127;
    return flhs_pkg::PCT_W'(val);
  endfunction

  task automatic note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED) $display("[%0t] FAILURE: %s", $time, what);
  endtask

  // Offers one request and returns at the rising edge where it transfers.
  // The prediction is made at that edge, so the shadow state always follows
  // the order in which the block takes requests.
  task automatic send_duty(input logic [flhs_pkg::PCT_W-1:0] duty);
    fan_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    duty_percent = duty;
    do @(posedge clk); while (!in_ready);
    res = step_fan_level(duty);
    expected_results.push_back(res);
    levels_reached[res.level] = 1'b1;
    curve_requests[curve_sel_q]++;
    requests_sent++;
    last_duty_sent = duty;
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // The select register is only touched while nothing is in flight.
  task automatic write_curve(input logic [flhs_pkg::TSEL_W-1:0] code);
    drain_results();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = code;
    @(negedge clk);
    cfg_we = 1'b0;
    curve_sel_q = code;
  endtask

  // Reset state and each curve: repeats, the on and off points, a full climb
  // to the top level, a request above 100 that clamps onto the previous 100,
  // and a fall to zero that would go below level 0. Also the spare table code.
  task automatic test_directed_curves();
    logic [flhs_pkg::PCT_W-1:0] curve_a_seq[16];
    logic [flhs_pkg::PCT_W-1:0] short_seq[3];
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    curve_a_seq = '{0, 36, 35, 57, 58, 1, 100, 127, 92, 91, 70, 69, 2, 1, 127, 0};
    for (k = 0; k < 16; k++) send_duty(curve_a_seq[k]);
    short_seq = '{98, 90, 0};
    write_curve(flhs_pkg::CURVE_C);
    for (k = 0; k < 3; k++) send_duty(short_seq[k]);
    write_curve(flhs_pkg::CURVE_B);
    for (k = 0; k < 3; k++) send_duty(short_seq[k]);
    write_curve(CURVE_SPARE);
    send_duty(7'd58);
    send_duty(7'd64);
    drain_results();
  endtask

  // The receiver refuses results for a long stretch while requests keep
  // coming, so the output register and the emit stage fill and the input
  // stalls. Afterwards the sender waits for a full drain before moving on.
  task automatic test_output_backpressure();
    int k;
    write_curve(flhs_pkg::CURVE_A);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_off_left = HOLD_OFF_CYCLES;
    for (k = 0; k < 30; k++) send_duty(pick_duty(last_duty_sent));
    drain_results();
    for (k = 0; k < 20; k++) send_duty(pick_duty(last_duty_sent));
    drain_results();
  endtask

  // One random phase: every table code in turn, the extremes included, with
  // the given idle rates on both channels.
  task automatic test_random_phase(input int send_pct, input int recv_pct, input int per_curve);
    logic [flhs_pkg::TSEL_W-1:0] order[4];
    int c;
    int k;
    order = '{flhs_pkg::CURVE_A, flhs_pkg::CURVE_C, flhs_pkg::CURVE_B, CURVE_SPARE};
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (c = 0; c < 4; c++) begin
      write_curve(order[c]);
      for (k = 0; k < per_curve; k++) send_duty(pick_duty(last_duty_sent));
    end
    drain_results();
  endtask

  // Clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: a long hold-off when one is asked for, otherwise random stalls.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready = 1'b0;
        hold_off_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result checker: every transfer on the output side is compared with the
  // oldest prediction, field by field.
  always @(posedge clk) begin : check_results
    fan_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result with nothing expected: rpm %0d level %0d",
                               target_rpm, fan_level));
      end else begin
        want = expected_results.pop_front();
        if (target_rpm !== want.rpm)
          note_failure($sformatf("target_rpm expected %0d, got %0d", want.rpm, target_rpm));
        if (fan_level !== want.level)
          note_failure($sformatf("fan_level expected %0d, got %0d", want.level, fan_level));
      end
    end
  end

  // Watchdog: well above the slowest legal run.
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("tb_fan_level_hysteresis_stepper_top NOT OK");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = flhs_pkg::CURVE_A;
    in_valid = 1'b0;
    duty_percent = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = 0;
    mismatch_count = 0;
    requests_sent = 0;
    results_seen = 0;
    curve_requests = '{0, 0, 0, 0};
    levels_reached = '0;
    last_duty_sent = '0;
    curve_sel_q = flhs_pkg::CURVE_A;
    level_q = '0;
    last_pct_q = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_directed_curves();
    test_output_backpressure();
    test_random_phase(10, 50, 100);
    test_random_phase(50, 10, 100);
    test_random_phase(0, 0, 100);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));

    $display("covered %0d requests and %0d results; per table code 0..3: %0d %0d %0d %0d",
             requests_sent, results_seen, curve_requests[0], curve_requests[1],
             curve_requests[2], curve_requests[3]);
    $display("levels reached (bit per level): %b; mismatches: %0d",
             levels_reached, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_fan_level_hysteresis_stepper_top OK");
    end else begin
      $display("tb_fan_level_hysteresis_stepper_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
sv/flhs_pkg.sv
sv/flhs_ctrl.sv
sv/flhs_datapath.sv
sv/fan_level_hysteresis_stepper_top.sv
sim/tb_fan_level_hysteresis_stepper_top.sv
